[hw/rtl/twlc_pkg.sv]
`timescale 1ns / 1ps

package twlc_pkg;

    // Fixed field widths.
    localparam int ADDR_W    = 20;
    localparam int DATA_W    = 32;
    localparam int COST_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_NUM   = 6;

    // Default geometry.
    localparam int DEF_BLOCK_OFFSET_BITS   = 6;
    localparam int DEF_FIRST_INDEX_BITS    = 8;
    localparam int DEF_SECOND_INDEX_BITS   = 9;
    localparam int DEF_MEMORY_ADDRESS_BITS = 20;

    // Cost register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_L1_READ   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_L1_WRITE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_READ   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_WRITE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_READ  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_WRITE = 3'd5;

    localparam logic [CFG_W-1:0] CFG_RESET [CFG_NUM] =
        '{16'd1, 16'd1, 16'd10, 16'd10, 16'd100, 16'd100};

    // Access kinds.
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
        logic              clear_cost;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [COST_W-1:0] total_cost;
        logic              first_level_hit;
    } rsp_t;

    // Block copy kinds run by the datapath copy engine.
    typedef enum logic [2:0] {
        CP_NONE,
        CP_L2_TO_BUF,
        CP_MEM_TO_L2,
        CP_L2_TO_MEM,
        CP_L1_TO_L2,
        CP_BUF_TO_L1
    } copy_t;

    // Which cost register is added to the counter.
    typedef enum logic [2:0] {
        COST_NONE,
        COST_L1_RD,
        COST_L1_WR,
        COST_L2_RD,
        COST_L2_WR,
        COST_MEM_RD,
        COST_MEM_WR
    } cost_sel_t;

    typedef struct packed {
        logic      accept;
        logic      tag1_from_port;
        logic      l1_latch;
        logic      l2blk_load;
        logic      l2blk_victim;
        logic      l2_latch;
        copy_t     copy;
        logic      word_we;
        logic      tag1_we;
        logic      tag1_dirty;
        logic      tag2_we;
        logic      tag2_dirty;
        cost_sel_t cost_sel;
        logic      finish;
        logic      clear;
    } cmd_t;

    typedef struct packed {
        logic l1_hit;
        logic l1_victim_dirty;
        logic l2_hit;
        logic l2_victim_dirty;
        logic copy_done;
        logic clear_done;
        logic is_write;
    } status_t;

endpackage

[hw/rtl/twlc_ram.sv]
`timescale 1ns / 1ps

module twlc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        rdata_reg <= store_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/twlc_ctrl.sv]
`timescale 1ns / 1ps

module twlc_ctrl import twlc_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_L1_CHK,
        S_L2_TAG,
        S_L2_CHK,
        S_L2_VICT,
        S_L2_FILL,
        S_L2_RDHIT,
        S_L2_WR,
        S_L1_AFTER,
        S_L1_FILL,
        S_WORD,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   wmode_reg, wmode_next;

    // State and second-level operation mode.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            wmode_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wmode_reg <= wmode_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // Next state and datapath commands.
    always_comb
    begin
        cmd        = '0;
        cmd.copy   = CP_NONE;
        cmd.cost_sel = COST_NONE;
        state_next = state_reg;
        wmode_next = wmode_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.tag1_from_port = 1'b1;
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_L1_CHK;
                end
            end
            S_L1_CHK:
            begin
                cmd.l1_latch = 1'b1;
                if (status.l1_hit)
                begin
                    cmd.word_we    = status.is_write;
                    cmd.tag1_we    = status.is_write;
                    cmd.tag1_dirty = 1'b1;
                    cmd.cost_sel   = status.is_write ? COST_L1_WR : COST_L1_RD;
                    state_next     = S_RESULT;
                end
                else
                begin
                    cmd.l2blk_load = 1'b1;
                    wmode_next     = 1'b0;
                    state_next     = S_L2_TAG;
                end
            end
            S_L2_TAG:
            begin
                state_next = S_L2_CHK;
            end
            S_L2_CHK:
            begin
                cmd.l2_latch = 1'b1;
                if (status.l2_hit)
                begin
                    cmd.cost_sel = wmode_reg ? COST_NONE : COST_L2_RD;
                    state_next   = wmode_reg ? S_L2_WR : S_L2_RDHIT;
                end
                else
                begin
                    cmd.cost_sel = COST_MEM_RD;
                    if (status.l2_victim_dirty)
                    begin
                        state_next = S_L2_VICT;
                    end
                    else
                    begin
                        state_next = wmode_reg ? S_L2_WR : S_L2_FILL;
                    end
                end
            end
            S_L2_VICT:
            begin
                cmd.copy = CP_L2_TO_MEM;
                if (status.copy_done)
                begin
                    cmd.cost_sel = COST_MEM_WR;
                    state_next   = wmode_reg ? S_L2_WR : S_L2_FILL;
                end
            end
            S_L2_FILL:
            begin
                cmd.copy = CP_MEM_TO_L2;
                if (status.copy_done)
                begin
                    cmd.tag2_we  = 1'b1;
                    cmd.cost_sel = COST_L2_RD;
                    state_next   = S_L1_AFTER;
                end
            end
            S_L2_RDHIT:
            begin
                cmd.copy = CP_L2_TO_BUF;
                if (status.copy_done)
                begin
                    state_next = S_L1_AFTER;
                end
            end
            S_L2_WR:
            begin
                cmd.copy = CP_L1_TO_L2;
                if (status.copy_done)
                begin
                    cmd.tag2_we    = 1'b1;
                    cmd.tag2_dirty = 1'b1;
                    cmd.cost_sel   = COST_L2_WR;
                    state_next     = S_L1_FILL;
                end
            end
            S_L1_AFTER:
            begin
                if (status.l1_victim_dirty)
                begin
                    cmd.l2blk_load   = 1'b1;
                    cmd.l2blk_victim = 1'b1;
                    wmode_next       = 1'b1;
                    state_next       = S_L2_TAG;
                end
                else
                begin
                    state_next = S_L1_FILL;
                end
            end
            S_L1_FILL:
            begin
                cmd.copy = CP_BUF_TO_L1;
                if (status.copy_done)
                begin
                    cmd.tag1_we = 1'b1;
                    state_next  = S_WORD;
                end
            end
            S_WORD:
            begin
                cmd.word_we    = status.is_write;
                cmd.tag1_we    = status.is_write;
                cmd.tag1_dirty = 1'b1;
                cmd.cost_sel   = status.is_write ? COST_L1_WR : COST_L1_RD;
                state_next     = S_RESULT;
            end
            S_RESULT:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/twlc_dpath.sv]
`timescale 1ns / 1ps

module twlc_dpath import twlc_pkg::*; #(
    parameter int BLOCK_OFFSET_BITS   = DEF_BLOCK_OFFSET_BITS,
    parameter int FIRST_INDEX_BITS    = DEF_FIRST_INDEX_BITS,
    parameter int SECOND_INDEX_BITS   = DEF_SECOND_INDEX_BITS,
    parameter int MEMORY_ADDRESS_BITS = DEF_MEMORY_ADDRESS_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  req_t                 request,
    input  cmd_t                 cmd,
    output status_t              status,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 done,
    output rsp_t                 result
);

    localparam int OFF = BLOCK_OFFSET_BITS;
    localparam int I1  = FIRST_INDEX_BITS;
    localparam int I2  = SECOND_INDEX_BITS;
    localparam int MA  = MEMORY_ADDRESS_BITS;
    localparam int WO  = OFF - 2;
    localparam int WPB = 1 << WO;
    localparam int MW  = MA - 2;
    localparam int MB  = MA - OFF;
    localparam int T1  = MB - I1;
    localparam int T2  = MB - I2;
    localparam int L1A = I1 + WO;
    localparam int L2A = I2 + WO;

    req_t              req_reg;
    logic [MA-1:0]     addr_m;
    logic [MA-1:0]     in_addr_m;
    logic [MB-1:0]     blk;
    logic [WO-1:0]     woff;
    logic [I1-1:0]     idx1;
    logic [T1-1:0]     tag1;
    logic [I2-1:0]     idx2;
    logic [T2-1:0]     tag2;

    logic              hit_reg;
    logic              l1_old_valid_reg;
    logic              l1_old_dirty_reg;
    logic [T1-1:0]     l1_old_tag_reg;
    logic [MB-1:0]     l2blk_reg;
    logic [T2-1:0]     l2_old_tag_reg;

    logic [WO:0]       cnt_reg;
    logic [WO:0]       cnt_dec;
    logic              copy_on;
    logic              copy_wr;
    logic [MW-1:0]     clr_reg;

    logic [COST_W-1:0] cost_reg;
    logic [CFG_W-1:0]  cost_add;
    logic [CFG_W-1:0]  cfg_reg [CFG_NUM];

    logic              done_reg;
    rsp_t              result_reg;

    logic              t1_we;
    logic [I1-1:0]     t1_waddr, t1_raddr;
    logic [T1+1:0]     t1_wdata, t1_rdata;
    logic              t2_we;
    logic [I2-1:0]     t2_waddr;
    logic [T2+1:0]     t2_wdata, t2_rdata;
    logic              w1_we;
    logic [L1A-1:0]    w1_waddr, w1_raddr;
    logic [DATA_W-1:0] w1_wdata, w1_rdata;
    logic              w2_we;
    logic [L2A-1:0]    w2_waddr, w2_raddr;
    logic [DATA_W-1:0] w2_wdata, w2_rdata;
    logic              m_we;
    logic [MW-1:0]     m_waddr, m_raddr;
    logic [DATA_W-1:0] m_wdata, m_rdata;
    logic              b_we;
    logic [DATA_W-1:0] b_wdata, b_rdata;

    // Address fields of the current item and of the second-level block.
    assign addr_m    = MA'(req_reg.address);
    assign in_addr_m = MA'(request.address);
    assign blk       = addr_m[MA-1:OFF];
    assign woff      = addr_m[OFF-1:2];
    assign idx1      = blk[I1-1:0];
    assign tag1      = blk[MB-1:I1];
    assign idx2      = l2blk_reg[I2-1:0];
    assign tag2      = l2blk_reg[MB-1:I2];

    // Copy engine: read word cnt, write the word read in the previous cycle.
    assign copy_on = (cmd.copy != CP_NONE);
    assign copy_wr = copy_on && (cnt_reg != '0);
    assign cnt_dec = cnt_reg - (WO+1)'(1);

    // Status toward the controller.
    always_comb
    begin
        status.l1_hit          = t1_rdata[T1+1] && (t1_rdata[T1-1:0] == tag1);
        status.l1_victim_dirty = l1_old_valid_reg && l1_old_dirty_reg;
        status.l2_hit          = t2_rdata[T2+1] && (t2_rdata[T2-1:0] == tag2);
        status.l2_victim_dirty = t2_rdata[T2+1] && t2_rdata[T2];
        status.copy_done       = copy_on && (cnt_reg == (WO+1)'(WPB));
        status.clear_done      = (clr_reg == '1);
        status.is_write        = (req_reg.kind == KIND_WRITE);
    end

    // First-level tag store: {valid, dirty, tag}.
    always_comb
    begin
        t1_raddr = cmd.tag1_from_port ? in_addr_m[OFF+I1-1:OFF] : idx1;
        t1_we    = cmd.clear || cmd.tag1_we;
        t1_waddr = cmd.clear ? clr_reg[I1-1:0] : idx1;
        t1_wdata = cmd.clear ? '0 : {1'b1, cmd.tag1_dirty, tag1};
    end

    // Second-level tag store.
    always_comb
    begin
        t2_we    = cmd.clear || cmd.tag2_we;
        t2_waddr = cmd.clear ? clr_reg[I2-1:0] : idx2;
        t2_wdata = cmd.clear ? '0 : {1'b1, cmd.tag2_dirty, tag2};
    end

    // First-level words: word access or block fill and drain.
    always_comb
    begin
        w1_raddr = {idx1, (cmd.copy == CP_L1_TO_L2) ? cnt_reg[WO-1:0] : woff};
        if (cmd.copy == CP_BUF_TO_L1)
        begin
            w1_we    = copy_wr;
            w1_waddr = {idx1, cnt_dec[WO-1:0]};
            w1_wdata = b_rdata;
        end
        else
        begin
            w1_we    = cmd.word_we;
            w1_waddr = {idx1, woff};
            w1_wdata = req_reg.write_data;
        end
    end

    // Second-level words.
    always_comb
    begin
        w2_raddr = {idx2, cnt_reg[WO-1:0]};
        w2_waddr = {idx2, cnt_dec[WO-1:0]};
        w2_we    = copy_wr && ((cmd.copy == CP_MEM_TO_L2) || (cmd.copy == CP_L1_TO_L2));
        w2_wdata = (cmd.copy == CP_MEM_TO_L2) ? m_rdata : w1_rdata;
    end

    // Main memory: zeroed by the sweep after reset, then block traffic only.
    always_comb
    begin
        m_raddr = {l2blk_reg, cnt_reg[WO-1:0]};
        if (cmd.clear)
        begin
            m_we    = 1'b1;
            m_waddr = clr_reg;
            m_wdata = '0;
        end
        else
        begin
            m_we    = copy_wr && (cmd.copy == CP_L2_TO_MEM);
            m_waddr = {l2_old_tag_reg, idx2, cnt_dec[WO-1:0]};
            m_wdata = w2_rdata;
        end
    end

    // Block buffer holding the block fetched for the first level.
    always_comb
    begin
        b_we    = copy_wr && ((cmd.copy == CP_MEM_TO_L2) || (cmd.copy == CP_L2_TO_BUF));
        b_wdata = (cmd.copy == CP_MEM_TO_L2) ? m_rdata : w2_rdata;
    end

    // Cost increment selection.
    always_comb
    begin
        case (cmd.cost_sel)
            COST_L1_RD:  cost_add = cfg_reg[CFG_L1_READ];
            COST_L1_WR:  cost_add = cfg_reg[CFG_L1_WRITE];
            COST_L2_RD:  cost_add = cfg_reg[CFG_L2_READ];
            COST_L2_WR:  cost_add = cfg_reg[CFG_L2_WRITE];
            COST_MEM_RD: cost_add = cfg_reg[CFG_MEM_READ];
            COST_MEM_WR: cost_add = cfg_reg[CFG_MEM_WRITE];
            default:     cost_add = '0;
        endcase
    end

    // Control counters, cost counter, cost registers and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            clr_reg  <= '0;
            cost_reg <= '0;
            done_reg <= 1'b0;
            for (int i = 0; i < CFG_NUM; i++)
            begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end
        else
        begin
            if (copy_on)
            begin
                cnt_reg <= status.copy_done ? '0 : cnt_reg + (WO+1)'(1);
            end
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + MW'(1);
            end
            if (cmd.accept && request.clear_cost)
            begin
                cost_reg <= '0;
            end
            else
            begin
                cost_reg <= cost_reg + COST_W'(cost_add);
            end
            done_reg <= cmd.finish;
            if (cfg_we && (cfg_index < CFG_IDX_W'(CFG_NUM)))
            begin
                cfg_reg[cfg_index] <= cfg_data;
            end
        end
    end

    // Item, latched tags and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= request;
        end
        if (cmd.l1_latch)
        begin
            hit_reg          <= status.l1_hit;
            l1_old_valid_reg <= t1_rdata[T1+1];
            l1_old_dirty_reg <= t1_rdata[T1];
            l1_old_tag_reg   <= t1_rdata[T1-1:0];
        end
        if (cmd.l2blk_load)
        begin
            l2blk_reg <= cmd.l2blk_victim ? {l1_old_tag_reg, idx1} : blk;
        end
        if (cmd.l2_latch)
        begin
            l2_old_tag_reg <= t2_rdata[T2-1:0];
        end
        if (cmd.finish)
        begin
            result_reg.read_data       <= status.is_write ? '0 : w1_rdata;
            result_reg.total_cost      <= cost_reg;
            result_reg.first_level_hit <= hit_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    twlc_ram #(.WIDTH(T1 + 2), .DEPTH(1 << I1)) u_tag1 (
        .clk(clk), .we(t1_we), .waddr(t1_waddr), .wdata(t1_wdata),
        .raddr(t1_raddr), .rdata(t1_rdata)
    );

    twlc_ram #(.WIDTH(T2 + 2), .DEPTH(1 << I2)) u_tag2 (
        .clk(clk), .we(t2_we), .waddr(t2_waddr), .wdata(t2_wdata),
        .raddr(idx2), .rdata(t2_rdata)
    );

    twlc_ram #(.WIDTH(DATA_W), .DEPTH(1 << L1A)) u_words1 (
        .clk(clk), .we(w1_we), .waddr(w1_waddr), .wdata(w1_wdata),
        .raddr(w1_raddr), .rdata(w1_rdata)
    );

    twlc_ram #(.WIDTH(DATA_W), .DEPTH(1 << L2A)) u_words2 (
        .clk(clk), .we(w2_we), .waddr(w2_waddr), .wdata(w2_wdata),
        .raddr(w2_raddr), .rdata(w2_rdata)
    );

    twlc_ram #(.WIDTH(DATA_W), .DEPTH(1 << MW)) u_main (
        .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
        .raddr(m_raddr), .rdata(m_rdata)
    );

    twlc_ram #(.WIDTH(DATA_W), .DEPTH(WPB)) u_buf (
        .clk(clk), .we(b_we), .waddr(cnt_dec[WO-1:0]), .wdata(b_wdata),
        .raddr(cnt_reg[WO-1:0]), .rdata(b_rdata)
    );

endmodule

[hw/rtl/two_level_writeback_cache.sv]
`timescale 1ns / 1ps

// Channel   Direction  Signals                        Transfer
// request   in         start, request (req_t), busy   start && !busy
// result    out        done, result (rsp_t)           done, one cycle
// config    in         cfg_we, cfg_index, cfg_data    cfg_we
//
// A first-level hit goes from acceptance through S_L1_CHK and S_RESULT to the registered done strobe.
// Every block copy streams one block over the word RAM ports, and each second-level
// tag lookup passes through S_L2_TAG and S_L2_CHK; a full double miss with dirty
// victims at every step runs five block copies.
// After reset the block sweeps main memory and both tag stores, one word a cycle,
// over all 2^(MEMORY_ADDRESS_BITS-2) words (262144 by default) with busy high.
// The receiver cannot stall: each item is shown for exactly one cycle.

module two_level_writeback_cache import twlc_pkg::*; #(
    parameter int BLOCK_OFFSET_BITS   = DEF_BLOCK_OFFSET_BITS,
    parameter int FIRST_INDEX_BITS    = DEF_FIRST_INDEX_BITS,
    parameter int SECOND_INDEX_BITS   = DEF_SECOND_INDEX_BITS,
    parameter int MEMORY_ADDRESS_BITS = DEF_MEMORY_ADDRESS_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  req_t                 request,
    output logic                 busy,
    output logic                 done,
    output rsp_t                 result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cmd_t    cmd;
    status_t status;

    twlc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start),
        .status(status), .cmd(cmd), .busy(busy)
    );

    twlc_dpath #(
        .BLOCK_OFFSET_BITS(BLOCK_OFFSET_BITS),
        .FIRST_INDEX_BITS(FIRST_INDEX_BITS),
        .SECOND_INDEX_BITS(SECOND_INDEX_BITS),
        .MEMORY_ADDRESS_BITS(MEMORY_ADDRESS_BITS)
    ) u_dpath (
        .clk(clk), .rst_n(rst_n), .request(request), .cmd(cmd),
        .status(status), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .result(result)
    );

`ifndef SYNTHESIS
    // A result only appears once the controller is back in idle.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result shown while busy");

    // An accepted item always keeps the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted item did not start work");

    // A result follows a busy cycle, never an idle one.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result without work");
`endif

endmodule
